[sv/hlle_riemann_flux_macros.svh]
// ----------------------------------------------------------------------------
// HLLE flux assertion macros
// Shared concurrent assertion forms, clocked on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef HLLE_RIEMANN_FLUX_MACROS_SVH
`define HLLE_RIEMANN_FLUX_MACROS_SVH

// same-cycle implication
`define HLLE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HLLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/hlle_pkg.sv]
// ----------------------------------------------------------------------------
// HLLE flux package
// Payload types, control bundle and constants shared by the flux pipeline.
// ----------------------------------------------------------------------------
package hlle_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIELD_WIDTH    = 32;
   localparam int COMP_WIDTH     = 3;

   localparam logic [COMP_WIDTH-1:0] COMP_XMOM   = 3'd1;
   localparam logic [COMP_WIDTH-1:0] COMP_ENERGY = 3'd3;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] left_wave;
      logic [FIELD_WIDTH-1:0] right_wave;
      logic [FIELD_WIDTH-1:0] left_velocity;
      logic [FIELD_WIDTH-1:0] right_velocity;
      logic [FIELD_WIDTH-1:0] left_pressure;
      logic [FIELD_WIDTH-1:0] right_pressure;
      logic [FIELD_WIDTH-1:0] left_value;
      logic [FIELD_WIDTH-1:0] right_value;
      logic [COMP_WIDTH-1:0]  component;
      logic                   direction;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] flux;
      logic                   saturated;
   } rsp_type;

   typedef struct packed {
      logic bypass;
      logic byp_clip;
      logic clip;
      logic neg;
      logic ovf;
   } ctl_type;

endpackage

[sv/hlle_riemann_flux.sv]
// A req passes seven front stages, one divider cell per quotient bit and an output
// register before rsp valid. Throughput: one face component per cycle; each of these
// stages advances when its successor frees.
// Reset: synchronous, clears every stage valid and the output valid; no payload clear.
// ----------------------------------------------------------------------------
// HLLE Riemann flux
// Streams one interface flux per transfer through a front end, a chain of
// divider cells and a saturating output register.
// ----------------------------------------------------------------------------
`include "hlle_riemann_flux_macros.svh"

module hlle_riemann_flux #(
   parameter int DATA_WIDTH = hlle_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = hlle_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hlle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hlle_pkg::rsp_type rsp_data
);

   localparam int W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int F = (FRAC_BITS > 32) ? 32 : FRAC_BITS;

   logic              req_rdy;
   logic [W:0]        lnk_valid;
   logic [W:0]        lnk_rdy;
   hlle_pkg::ctl_type lnk_ctl [W+1];
   logic [W:0]        lnk_rem [W+1];
   logic [W-1:0]      lnk_quo [W+1];
   logic [W-1:0]      lnk_low [W+1];
   logic [W:0]        lnk_den [W+1];
   logic [W-1:0]      lnk_byp [W+1];

   assign req_stall = !req_rdy;

   hlle_front #(
      .DATA_WIDTH (W),
      .FRAC_BITS  (F)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_rdy),
      .in_data   (req_data),
      .out_valid (lnk_valid[0]),
      .out_ready (lnk_rdy[0]),
      .out_ctl   (lnk_ctl[0]),
      .out_rem   (lnk_rem[0]),
      .out_low   (lnk_low[0]),
      .out_den   (lnk_den[0]),
      .out_byp   (lnk_byp[0])
   );

   assign lnk_quo[0] = '0;

   for (genvar i = 0; i < W; i++) begin : g_cell
      hlle_div_cell #(
         .DATA_WIDTH (W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lnk_valid[i]),
         .in_ready  (lnk_rdy[i]),
         .in_ctl    (lnk_ctl[i]),
         .in_rem    (lnk_rem[i]),
         .in_quo    (lnk_quo[i]),
         .in_low    (lnk_low[i]),
         .in_den    (lnk_den[i]),
         .in_byp    (lnk_byp[i]),
         .out_valid (lnk_valid[i+1]),
         .out_ready (lnk_rdy[i+1]),
         .out_ctl   (lnk_ctl[i+1]),
         .out_rem   (lnk_rem[i+1]),
         .out_quo   (lnk_quo[i+1]),
         .out_low   (lnk_low[i+1]),
         .out_den   (lnk_den[i+1]),
         .out_byp   (lnk_byp[i+1])
      );
   end

   // output register
   logic              rsp_valid_ff;
   hlle_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              out_rdy;
   logic [W-1:0]      q, vmax, vmin;
   logic signed [W-1:0] val;
   logic              big;
   hlle_pkg::ctl_type c;

   assign out_rdy    = !rsp_valid_ff || !rsp_stall;
   assign lnk_rdy[W] = out_rdy;

   always_comb begin
      c    = lnk_ctl[W];
      q    = lnk_quo[W];
      vmax = {1'b0, {(W-1){1'b1}}};
      vmin = {1'b1, {(W-1){1'b0}}};
      big  = c.ovf || (!c.neg && q[W-1]) || (c.neg && q[W-1] && (|q[W-2:0]));
      rsp_data_in = '0;
      if (c.bypass) begin
         val                   = $signed(lnk_byp[W]);
         rsp_data_in.saturated = c.byp_clip;
      end else if (big) begin
         val                   = $signed(c.neg ? vmin : vmax);
         rsp_data_in.saturated = 1'b1;
      end else begin
         val                   = c.neg ? $signed(-q) : $signed(q);
         rsp_data_in.saturated = c.clip;
      end
      rsp_data_in.flux = hlle_pkg::FIELD_WIDTH'(val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= lnk_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HLLE_ASSERT_NEXT(a_cell_to_rsp, lnk_valid[W] && out_rdy, rsp_valid_ff, "cell result lost at output")
   `HLLE_ASSERT_IMPL(a_rem_below_den, lnk_valid[W] && !lnk_ctl[W].bypass && !lnk_ctl[W].ovf, lnk_rem[W] < lnk_den[W], "divider remainder not below divisor")
   `HLLE_ASSERT_IMPL(a_flux_sext, rsp_valid_ff, (($signed(rsp_data_ff.flux) >>> (W-1)) == 0) || (($signed(rsp_data_ff.flux) >>> (W-1)) == -1), "flux not sign extended from data width")

endmodule

[sv/hlle_front.sv]
// ----------------------------------------------------------------------------
// HLLE flux front end
// Products, physical fluxes, case select, blend numerator and divider setup.
// ----------------------------------------------------------------------------
module hlle_front #(
   parameter int DATA_WIDTH = hlle_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = hlle_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hlle_pkg::req_type     in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hlle_pkg::ctl_type     out_ctl,
   output logic [DATA_WIDTH:0]   out_rem,
   output logic [DATA_WIDTH-1:0] out_low,
   output logic [DATA_WIDTH:0]   out_den,
   output logic [DATA_WIDTH-1:0] out_byp
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int SW = 2 * W + 2;
   localparam int NW = 3 * W + F + 3;
   localparam int NS = 7;

   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 1: products
   logic signed [W-1:0] lw, rw, lv, rv, lp, rp, lq, rq;
   assign lw = $signed(in_data.left_wave[W-1:0]);
   assign rw = $signed(in_data.right_wave[W-1:0]);
   assign lv = $signed(in_data.left_velocity[W-1:0]);
   assign rv = $signed(in_data.right_velocity[W-1:0]);
   assign lp = $signed(in_data.left_pressure[W-1:0]);
   assign rp = $signed(in_data.right_pressure[W-1:0]);
   assign lq = $signed(in_data.left_value[W-1:0]);
   assign rq = $signed(in_data.right_value[W-1:0]);

   logic signed [2*W-1:0] qvl_ff, pvl_ff, qvr_ff, pvr_ff, ww1_ff;
   logic signed [W-1:0]   lw1_ff, rw1_ff, lp1_ff, rp1_ff;
   logic signed [W:0]     d1_ff, d1_in;
   logic [W:0]            den1_ff, den1_in;
   logic                  nrm1_ff, nrm1_in, nrg1_ff, nrg1_in;

   always_comb begin
      d1_in   = $signed({rq[W-1], rq}) - $signed({lq[W-1], lq});
      den1_in = {rw[W-1], rw} - {lw[W-1], lw};
      nrm1_in = in_data.component ==
                (hlle_pkg::COMP_XMOM + {{(hlle_pkg::COMP_WIDTH-1){1'b0}}, in_data.direction});
      nrg1_in = in_data.component == hlle_pkg::COMP_ENERGY;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         qvl_ff  <= lq * lv;
         pvl_ff  <= lp * lv;
         qvr_ff  <= rq * rv;
         pvr_ff  <= rp * rv;
         ww1_ff  <= rw * lw;
         lw1_ff  <= lw;
         rw1_ff  <= rw;
         lp1_ff  <= lp;
         rp1_ff  <= rp;
         d1_ff   <= d1_in;
         den1_ff <= den1_in;
         nrm1_ff <= nrm1_in;
         nrg1_ff <= nrg1_in;
      end
   end

   // stage 2: physical fluxes, saturated
   logic signed [SW-1:0] lsum, rsum, smax, smin;
   logic signed [W-1:0]  lf2_ff, rf2_ff, lf2_in, rf2_in, lw2_ff, rw2_ff;
   logic                 lclip2_ff, rclip2_ff, lclip2_in, rclip2_in;
   logic signed [2*W-1:0] ww2_ff;
   logic signed [W:0]    d2_ff;
   logic [W:0]           den2_ff;

   always_comb begin
      smax = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
      smin = ~smax;
      lsum = SW'(qvl_ff >>> F) + (nrm1_ff ? SW'(lp1_ff) : '0)
           + (nrg1_ff ? SW'(pvl_ff >>> F) : '0);
      rsum = SW'(qvr_ff >>> F) + (nrm1_ff ? SW'(rp1_ff) : '0)
           + (nrg1_ff ? SW'(pvr_ff >>> F) : '0);
      lclip2_in = (lsum > smax) || (lsum < smin);
      rclip2_in = (rsum > smax) || (rsum < smin);
      lf2_in = (lsum > smax) ? smax[W-1:0] : (lsum < smin) ? smin[W-1:0] : lsum[W-1:0];
      rf2_in = (rsum > smax) ? smax[W-1:0] : (rsum < smin) ? smin[W-1:0] : rsum[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         lf2_ff    <= lf2_in;
         rf2_ff    <= rf2_in;
         lclip2_ff <= lclip2_in;
         rclip2_ff <= rclip2_in;
         lw2_ff    <= lw1_ff;
         rw2_ff    <= rw1_ff;
         ww2_ff    <= ww1_ff;
         d2_ff     <= d1_ff;
         den2_ff   <= den1_ff;
      end
   end

   // stage 3: blend products and case select
   logic signed [2*W-1:0] lfrw3_ff, rflw3_ff;
   logic signed [2*W+1:0] pdl3_ff;
   logic signed [2*W:0]   pdh3_ff;
   hlle_pkg::ctl_type     ctl3_ff, ctl3_in;
   logic [W-1:0]          byp3_ff, byp3_in;
   logic [W:0]            den3_ff;

   always_comb begin
      ctl3_in      = '0;
      ctl3_in.clip = lclip2_ff || rclip2_ff;
      byp3_in      = '0;
      if (lw2_ff == '0 && rw2_ff == '0) begin
         ctl3_in.bypass = 1'b1;
      end else if (rw2_ff <= 0) begin
         ctl3_in.bypass   = 1'b1;
         ctl3_in.byp_clip = rclip2_ff;
         byp3_in          = rf2_ff;
      end else if (lw2_ff >= 0) begin
         ctl3_in.bypass   = 1'b1;
         ctl3_in.byp_clip = lclip2_ff;
         byp3_in          = lf2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         lfrw3_ff <= lf2_ff * rw2_ff;
         rflw3_ff <= rf2_ff * lw2_ff;
         pdl3_ff  <= $signed({1'b0, ww2_ff[W-1:0]}) * d2_ff;
         pdh3_ff  <= $signed(ww2_ff[2*W-1:W]) * d2_ff;
         ctl3_ff  <= ctl3_in;
         byp3_ff  <= byp3_in;
         den3_ff  <= den2_ff;
      end
   end

   // stage 4: partial sums
   logic signed [2*W:0]  a4_ff, a4_in;
   logic signed [NW-1:0] b4_ff, b4_in;
   hlle_pkg::ctl_type    ctl4_ff;
   logic [W-1:0]         byp4_ff;
   logic [W:0]           den4_ff;

   always_comb begin
      a4_in = (2*W+1)'(lfrw3_ff) - (2*W+1)'(rflw3_ff);
      b4_in = (NW'(pdh3_ff) <<< W) + NW'(pdl3_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         a4_ff   <= a4_in;
         b4_ff   <= b4_in;
         ctl4_ff <= ctl3_ff;
         byp4_ff <= byp3_ff;
         den4_ff <= den3_ff;
      end
   end

   // stage 5: numerator
   logic signed [NW-1:0] num5_ff, num5_in;
   hlle_pkg::ctl_type    ctl5_ff;
   logic [W-1:0]         byp5_ff;
   logic [W:0]           den5_ff;

   assign num5_in = (NW'(a4_ff) <<< F) + b4_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         num5_ff <= num5_in;
         ctl5_ff <= ctl4_ff;
         byp5_ff <= byp4_ff;
         den5_ff <= den4_ff;
      end
   end

   // stage 6: sign and magnitude
   logic [NW-1:0]     mag6_ff, mag6_in;
   hlle_pkg::ctl_type ctl6_ff, ctl6_in;
   logic [W-1:0]      byp6_ff;
   logic [W:0]        den6_ff;

   always_comb begin
      ctl6_in     = ctl5_ff;
      ctl6_in.neg = num5_ff[NW-1];
      mag6_in     = num5_ff[NW-1] ? NW'(-num5_ff) : NW'(num5_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         mag6_ff <= mag6_in;
         ctl6_ff <= ctl6_in;
         byp6_ff <= byp5_ff;
         den6_ff <= den5_ff;
      end
   end

   // stage 7: drop fraction, overflow check, seed remainder
   logic [NW-1:0]     sh7, hi7;
   hlle_pkg::ctl_type ctl7_ff, ctl7_in;
   logic [W:0]        rem7_ff, den7_ff;
   logic [W-1:0]      low7_ff, byp7_ff;

   always_comb begin
      sh7         = mag6_ff >> F;
      hi7         = sh7 >> W;
      ctl7_in     = ctl6_ff;
      ctl7_in.ovf = hi7 >= NW'(den6_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         ctl7_ff <= ctl7_in;
         rem7_ff <= hi7[W:0];
         low7_ff <= sh7[W-1:0];
         den7_ff <= den6_ff;
         byp7_ff <= byp6_ff;
      end
   end

   assign out_ctl = ctl7_ff;
   assign out_rem = rem7_ff;
   assign out_low = low7_ff;
   assign out_den = den7_ff;
   assign out_byp = byp7_ff;

endmodule

[sv/hlle_div_cell.sv]
// ----------------------------------------------------------------------------
// HLLE divider cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module hlle_div_cell #(
   parameter int DATA_WIDTH = hlle_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hlle_pkg::ctl_type     in_ctl,
   input  logic [DATA_WIDTH:0]   in_rem,
   input  logic [DATA_WIDTH-1:0] in_quo,
   input  logic [DATA_WIDTH-1:0] in_low,
   input  logic [DATA_WIDTH:0]   in_den,
   input  logic [DATA_WIDTH-1:0] in_byp,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hlle_pkg::ctl_type     out_ctl,
   output logic [DATA_WIDTH:0]   out_rem,
   output logic [DATA_WIDTH-1:0] out_quo,
   output logic [DATA_WIDTH-1:0] out_low,
   output logic [DATA_WIDTH:0]   out_den,
   output logic [DATA_WIDTH-1:0] out_byp
);

   localparam int W = DATA_WIDTH;

   logic              valid_ff;
   hlle_pkg::ctl_type ctl_ff;
   logic [W:0]        rem_ff, rem_in, den_ff;
   logic [W-1:0]      quo_ff, quo_in, low_ff, low_in, byp_ff;
   logic [W+1:0]      trial, diff;
   logic              ge;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial  = {in_rem, in_low[W-1]};
      diff   = trial - {1'b0, in_den};
      ge     = trial >= {1'b0, in_den};
      rem_in = ge ? diff[W:0] : trial[W:0];
      quo_in = {in_quo[W-2:0], ge};
      low_in = {in_low[W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff <= in_ctl;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         low_ff <= low_in;
         den_ff <= in_den;
         byp_ff <= in_byp;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_low   = low_ff;
   assign out_den   = den_ff;
   assign out_byp   = byp_ff;

endmodule
